### hdl/im2col_pkg.sv
package im2col_pkg;

  localparam int IMG_W  = 12;
  localparam int WIN_W  = 5;
  localparam int PAD_W  = 4;
  localparam int STEP_W = 5;
  localparam int OFFS_W = 24;
  localparam int KCNT_W = 4;
  // Padded extent along one axis: 12-bit size plus twice a 4-bit pad.
  localparam int SPAN_W = 13;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(16);

  typedef enum logic [2:0] {
    REG_IMAGE_HEIGHT  = 3'd0,
    REG_IMAGE_WIDTH   = 3'd1,
    REG_WINDOW_HEIGHT = 3'd2,
    REG_WINDOW_WIDTH  = 3'd3,
    REG_PAD_ROWS      = 3'd4,
    REG_PAD_COLS      = 3'd5,
    REG_STEP_ROWS     = 3'd6,
    REG_STEP_COLS     = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_POS,
    ST_EMIT,
    ST_ERR
  } ctrl_state_e;

  typedef struct packed {
    logic [IMG_W-1:0]  image_height;
    logic [IMG_W-1:0]  image_width;
    logic [WIN_W-1:0]  window_height;
    logic [WIN_W-1:0]  window_width;
    logic [PAD_W-1:0]  pad_rows;
    logic [PAD_W-1:0]  pad_cols;
    logic [STEP_W-1:0] step_rows;
    logic [STEP_W-1:0] step_cols;
  } cfg_t;

  typedef struct packed {
    logic pass_init;
    logic latch_dims;
    logic set_active;
    logic load_prod;
    logic load_pos;
    logic load_out;
    logic load_err;
  } cmd_t;

  typedef struct packed {
    logic pass_active;
    logic geo_err;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic logic [WIN_W-1:0] fix_window(input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] r;
    if (w == '0) begin
      r = WIN_W'(1);
    end else if (w > WIN_MAX) begin
      r = WIN_MAX;
    end else begin
      r = w;
    end
    return r;
  endfunction

  function automatic logic [STEP_W-1:0] fix_step(input logic [STEP_W-1:0] s);
    return (s == '0) ? STEP_W'(1) : s;
  endfunction

endpackage

### hdl/im2col_address_generator.sv
// Flow: an entry inside a running pass is registered in turn as product, position and output,
// the output step waiting while a result is still held; the first entry of a pass (or a geometry
// error) first waits for the 13-step serial divider that works out the output height and width.
// Requests: a new request is taken only back in idle, after the previous entry or error is loaded;
// a request that opens a pass holds the input through the divider and the geometry check as well.
// Reset (asynchronous, active low): no pass open, counters zero, registers at their defaults.
module im2col_address_generator
  import im2col_pkg::*;
#(
  parameter int ROW_DIL  = 1,
  parameter int COL_DIL  = 1,
  parameter int DIM_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              restart_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OFFS_W-1:0] source_offset_o,
  output logic              is_padding_o,
  output logic              last_o,
  output logic              geometry_error_o
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  im2col_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  im2col_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  im2col_datapath #(
    .ROW_DIL  (ROW_DIL),
    .COL_DIL  (COL_DIL),
    .DIM_BITS (DIM_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .source_offset_o  (source_offset_o),
    .is_padding_o     (is_padding_o),
    .last_o           (last_o),
    .geometry_error_o (geometry_error_o)
  );

endmodule

### hdl/im2col_cfg_regs.sv
module im2col_cfg_regs
  import im2col_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[4:2]);
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_IMAGE_HEIGHT:  cfg_d.image_height  = pwdata[IMG_W-1:0];
        REG_IMAGE_WIDTH:   cfg_d.image_width   = pwdata[IMG_W-1:0];
        REG_WINDOW_HEIGHT: cfg_d.window_height = pwdata[WIN_W-1:0];
        REG_WINDOW_WIDTH:  cfg_d.window_width  = pwdata[WIN_W-1:0];
        REG_PAD_ROWS:      cfg_d.pad_rows      = pwdata[PAD_W-1:0];
        REG_PAD_COLS:      cfg_d.pad_cols      = pwdata[PAD_W-1:0];
        REG_STEP_ROWS:     cfg_d.step_rows     = pwdata[STEP_W-1:0];
        REG_STEP_COLS:     cfg_d.step_cols     = pwdata[STEP_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IMAGE_HEIGHT:  prdata = DATA_W'(cfg_q.image_height);
      REG_IMAGE_WIDTH:   prdata = DATA_W'(cfg_q.image_width);
      REG_WINDOW_HEIGHT: prdata = DATA_W'(cfg_q.window_height);
      REG_WINDOW_WIDTH:  prdata = DATA_W'(cfg_q.window_width);
      REG_PAD_ROWS:      prdata = DATA_W'(cfg_q.pad_rows);
      REG_PAD_COLS:      prdata = DATA_W'(cfg_q.pad_cols);
      REG_STEP_ROWS:     prdata = DATA_W'(cfg_q.step_rows);
      REG_STEP_COLS:     prdata = DATA_W'(cfg_q.step_cols);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_height  <= IMG_W'(1);
      cfg_q.image_width   <= IMG_W'(1);
      cfg_q.window_height <= WIN_W'(1);
      cfg_q.window_width  <= WIN_W'(1);
      cfg_q.pad_rows      <= '0;
      cfg_q.pad_cols      <= '0;
      cfg_q.step_rows     <= STEP_W'(1);
      cfg_q.step_cols     <= STEP_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/im2col_div.sv
module im2col_div #(
  parameter int N_W = 13,
  parameter int D_W = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic           busy_o,
  output logic [N_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [N_W-1:0]   quot_q, quot_d;
  logic [D_W-1:0]   rem_q, rem_d;
  logic [D_W:0]     shifted;
  logic [D_W+1:0]   diff;
  logic             ge;

  // Restoring division, one quotient bit per cycle.
  assign shifted = {rem_q, quot_q[N_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor_i};
  assign ge      = ~diff[D_W+1];

  always_comb begin
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      cnt_d  = CNT_W'(N_W);
      quot_d = dividend_i;
      rem_d  = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CNT_W'(1);
      quot_d = {quot_q[N_W-2:0], ge};
      rem_d  = ge ? diff[D_W-1:0] : shifted[D_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;

endmodule

### hdl/im2col_datapath.sv
module im2col_datapath
  import im2col_pkg::*;
#(
  parameter int ROW_DIL  = 1,
  parameter int COL_DIL  = 1,
  parameter int DIM_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [OFFS_W-1:0] source_offset_o,
  output logic              is_padding_o,
  output logic              last_o,
  output logic              geometry_error_o
);

  localparam int PROD_W = DIM_BITS + STEP_W;
  localparam int POS_W  = ((PROD_W > IMG_W) ? PROD_W : IMG_W) + 2;
  localparam int CMP_W  = ((DIM_BITS > SPAN_W) ? DIM_BITS : SPAN_W) + 1;
  localparam int LIM    = (1 << DIM_BITS) - 1;

  logic [WIN_W-1:0]  wh, ww;
  logic [STEP_W-1:0] sr, sc;
  logic [SPAN_W-1:0] padded_r, padded_c, extent_r, extent_c;
  logic [SPAN_W-1:0] quot_r, quot_c;
  logic              busy_r, busy_c;
  logic [CMP_W-1:0]  n_r, n_c;
  logic [DIM_BITS-1:0] rows_d, cols_d;

  logic [DIM_BITS-1:0] rows_q, cols_q;
  logic [KCNT_W-1:0]   kr_q, kc_q;
  logic [DIM_BITS-1:0] orow_q, ocol_q;
  logic                active_q, geo_err_q;

  logic [PROD_W-1:0] prod_r_q, prod_c_q;
  logic [POS_W-1:0]  srow, scol;
  logic              in_r, in_c;
  logic [IMG_W-1:0]  row_q, col_q;
  logic              inside_q;

  logic              last_c;
  logic              kr_end, kc_end, orow_end, ocol_end;
  logic [OFFS_W-1:0] offset_c;

  logic              out_valid_q;
  logic [OFFS_W-1:0] offset_q;
  logic              pad_q, last_q, err_q;

  assign wh = fix_window(cfg_i.window_height);
  assign ww = fix_window(cfg_i.window_width);
  assign sr = fix_step(cfg_i.step_rows);
  assign sc = fix_step(cfg_i.step_cols);

  assign padded_r = SPAN_W'(cfg_i.image_height) + SPAN_W'({cfg_i.pad_rows, 1'b0});
  assign padded_c = SPAN_W'(cfg_i.image_width) + SPAN_W'({cfg_i.pad_cols, 1'b0});
  assign extent_r = SPAN_W'(wh - WIN_W'(1)) * SPAN_W'(ROW_DIL) + SPAN_W'(1);
  assign extent_c = SPAN_W'(ww - WIN_W'(1)) * SPAN_W'(COL_DIL) + SPAN_W'(1);

  // Both output dimensions are divided in parallel when a pass opens.
  im2col_div #(.N_W(SPAN_W), .D_W(STEP_W)) u_div_rows (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.pass_init),
    .dividend_i (padded_r - extent_r),
    .divisor_i  (sr),
    .busy_o     (busy_r),
    .quot_o     (quot_r)
  );

  im2col_div #(.N_W(SPAN_W), .D_W(STEP_W)) u_div_cols (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.pass_init),
    .dividend_i (padded_c - extent_c),
    .divisor_i  (sc),
    .busy_o     (busy_c),
    .quot_o     (quot_c)
  );

  assign n_r    = CMP_W'(quot_r) + CMP_W'(1);
  assign n_c    = CMP_W'(quot_c) + CMP_W'(1);
  assign rows_d = (n_r > CMP_W'(LIM)) ? DIM_BITS'(LIM) : n_r[DIM_BITS-1:0];
  assign cols_d = (n_c > CMP_W'(LIM)) ? DIM_BITS'(LIM) : n_c[DIM_BITS-1:0];

  assign kr_end   = ({1'b0, kr_q} + WIN_W'(1)) >= wh;
  assign kc_end   = ({1'b0, kc_q} + WIN_W'(1)) >= ww;
  assign orow_end = ({1'b0, orow_q} + (DIM_BITS+1)'(1)) >= {1'b0, rows_q};
  assign ocol_end = ({1'b0, ocol_q} + (DIM_BITS+1)'(1)) >= {1'b0, cols_q};
  assign last_c   = kr_end & kc_end & orow_end & ocol_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q    <= '0;
      cols_q    <= '0;
      kr_q      <= '0;
      kc_q      <= '0;
      orow_q    <= '0;
      ocol_q    <= '0;
      active_q  <= 1'b0;
      geo_err_q <= 1'b0;
    end else begin
      if (cmd_i.pass_init) begin
        kr_q      <= '0;
        kc_q      <= '0;
        orow_q    <= '0;
        ocol_q    <= '0;
        active_q  <= 1'b0;
        geo_err_q <= (padded_r < extent_r) | (padded_c < extent_c);
      end
      if (cmd_i.latch_dims) begin
        rows_q <= rows_d;
        cols_q <= cols_d;
      end
      if (cmd_i.set_active) begin
        active_q <= 1'b1;
      end
      if (cmd_i.load_err) begin
        active_q <= 1'b0;
      end
      if (cmd_i.load_out) begin
        if (last_c) begin
          active_q <= 1'b0;
          kr_q     <= '0;
          kc_q     <= '0;
          orow_q   <= '0;
          ocol_q   <= '0;
        end else if (!ocol_end) begin
          ocol_q <= ocol_q + DIM_BITS'(1);
        end else begin
          ocol_q <= '0;
          if (!orow_end) begin
            orow_q <= orow_q + DIM_BITS'(1);
          end else begin
            orow_q <= '0;
            if (!kc_end) begin
              kc_q <= kc_q + KCNT_W'(1);
            end else begin
              kc_q <= '0;
              kr_q <= kr_end ? '0 : kr_q + KCNT_W'(1);
            end
          end
        end
      end
    end
  end

  // Window position: kernel offset plus output position times stride, minus padding.
  assign srow = POS_W'(prod_r_q) + POS_W'(kr_q) * POS_W'(ROW_DIL)
              - POS_W'(cfg_i.pad_rows);
  assign scol = POS_W'(prod_c_q) + POS_W'(kc_q) * POS_W'(COL_DIL)
              - POS_W'(cfg_i.pad_cols);
  assign in_r = ~srow[POS_W-1] & (srow[POS_W-2:0] < (POS_W-1)'(cfg_i.image_height));
  assign in_c = ~scol[POS_W-1] & (scol[POS_W-2:0] < (POS_W-1)'(cfg_i.image_width));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_prod) begin
      prod_r_q <= PROD_W'(orow_q) * PROD_W'(sr);
      prod_c_q <= PROD_W'(ocol_q) * PROD_W'(sc);
    end
    if (cmd_i.load_pos) begin
      row_q    <= srow[IMG_W-1:0];
      col_q    <= scol[IMG_W-1:0];
      inside_q <= in_r & in_c;
    end
  end

  assign offset_c = OFFS_W'(row_q) * OFFS_W'(cfg_i.image_width) + OFFS_W'(col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out || cmd_i.load_err) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      offset_q <= inside_q ? offset_c : '0;
      pad_q    <= ~inside_q;
      last_q   <= last_c;
      err_q    <= 1'b0;
    end else if (cmd_i.load_err) begin
      offset_q <= '0;
      pad_q    <= 1'b0;
      last_q   <= 1'b1;
      err_q    <= 1'b1;
    end
  end

  assign sts_o.pass_active = active_q;
  assign sts_o.geo_err     = geo_err_q;
  assign sts_o.div_done    = ~busy_r & ~busy_c;
  assign sts_o.out_free    = ~out_valid_q | out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign source_offset_o  = offset_q;
  assign is_padding_o     = pad_q;
  assign last_o           = last_q;
  assign geometry_error_o = err_q;

endmodule

### hdl/im2col_ctrl.sv
module im2col_ctrl
  import im2col_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic restart_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (restart_i || !sts_i.pass_active) ? ST_DIV : ST_POS;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: state_d = sts_i.geo_err ? ST_ERR : ST_POS;
      ST_POS:   state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (restart_i || !sts_i.pass_active) begin
            cmd_o.pass_init = 1'b1;
          end else begin
            cmd_o.load_prod = 1'b1;
          end
        end
      end
      ST_DIV:   cmd_o.latch_dims = sts_i.div_done;
      ST_CHECK: begin
        if (!sts_i.geo_err) begin
          cmd_o.set_active = 1'b1;
          cmd_o.load_prod  = 1'b1;
        end
      end
      ST_POS:   cmd_o.load_pos = 1'b1;
      ST_EMIT:  cmd_o.load_out = sts_i.out_free;
      ST_ERR:   cmd_o.load_err = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sim/im2col_order_checker.sv
`timescale 1ns / 1ps
module im2col_order_checker
  import im2col_pkg::*;
#(
  parameter int DIL_H    = 1,
  parameter int DIL_W    = 1,
  parameter int DIM_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              restart_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [OFFS_W-1:0] source_offset_i,
  input  logic              is_padding_i,
  input  logic              last_i,
  input  logic              geometry_error_i,
  output int                error_count_o,
  output int                pending_o
);

  localparam int DIM_LIMIT = (1 << DIM_BITS) - 1;

  typedef struct packed {
    logic [OFFS_W-1:0] offset;
    logic              padding;
    logic              last;
    logic              geo_err;
  } column_entry_t;

  cfg_t          shadow_cfg;
  int            krow;
  int            kcol;
  int            out_row;
  int            out_col;
  int            rows_latched;
  int            cols_latched;
  bit            pass_open;
  column_entry_t column_q[$];

  // Output positions along one axis, capped at DIM_LIMIT; zero when the padded extent cannot hold the window.
  function automatic int output_count(input int size, input int pad, input int win,
                                      input int dil, input int step);
    int padded;
    int extent;
    int n;
    padded = size + 2 * pad;
    extent = dil * (win - 1) + 1;
    if (padded < extent) begin
      return 0;
    end
    n = (padded - extent) / step + 1;
    return (n > DIM_LIMIT) ? DIM_LIMIT : n;
  endfunction

  function automatic int clamp_window(input logic [WIN_W-1:0] w);
    int v;
    v = int'(w);
    if (v == 0) begin
      return 1;
    end
    return (v > 16) ? 16 : v;
  endfunction

  function automatic column_entry_t next_entry(input logic fresh);
    column_entry_t e;
    int            wh;
    int            ww;
    int            sr;
    int            sc;
    int            ih;
    int            iw;
    int            srow;
    int            scol;
    bit            fin;
    wh = clamp_window(shadow_cfg.window_height);
    ww = clamp_window(shadow_cfg.window_width);
    sr = (shadow_cfg.step_rows == '0) ? 1 : int'(shadow_cfg.step_rows);
    sc = (shadow_cfg.step_cols == '0) ? 1 : int'(shadow_cfg.step_cols);
    ih = int'(shadow_cfg.image_height);
    iw = int'(shadow_cfg.image_width);
    e = '0;
    if (fresh || !pass_open) begin
      rows_latched = output_count(ih, int'(shadow_cfg.pad_rows), wh, DIL_H, sr);
      cols_latched = output_count(iw, int'(shadow_cfg.pad_cols), ww, DIL_W, sc);
      krow = 0;
      kcol = 0;
      out_row = 0;
      out_col = 0;
      if (rows_latched == 0 || cols_latched == 0) begin
        pass_open = 1'b0;
        e.last = 1'b1;
        e.geo_err = 1'b1;
        return e;
      end
      pass_open = 1'b1;
    end

    srow = krow * DIL_H + out_row * sr - int'(shadow_cfg.pad_rows);
    scol = kcol * DIL_W + out_col * sc - int'(shadow_cfg.pad_cols);
    if (srow >= 0 && srow < ih && scol >= 0 && scol < iw) begin
      e.offset = OFFS_W'(longint'(srow) * iw + scol);
    end else begin
      e.padding = 1'b1;
    end

    fin = (krow + 1 >= wh) && (kcol + 1 >= ww) &&
          (out_row + 1 >= rows_latched) && (out_col + 1 >= cols_latched);
    e.last = fin;

    // Output column runs fastest, kernel row slowest. Counters left past a limit by a
    // live window change wrap on their next advance.
    if (fin) begin
      pass_open = 1'b0;
      krow = 0;
      kcol = 0;
      out_row = 0;
      out_col = 0;
    end else if (out_col + 1 < cols_latched) begin
      out_col++;
    end else begin
      out_col = 0;
      if (out_row + 1 < rows_latched) begin
        out_row++;
      end else begin
        out_row = 0;
        if (kcol + 1 < ww) begin
          kcol++;
        end else begin
          kcol = 0;
          krow = (krow + 1 < wh) ? krow + 1 : 0;
        end
      end
    end
    krow &= 'hF;
    kcol &= 'hF;
    return e;
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    column_entry_t want;
    if (!rst_ni) begin
      shadow_cfg               = '0;
      shadow_cfg.image_height  = IMG_W'(1);
      shadow_cfg.image_width   = IMG_W'(1);
      shadow_cfg.window_height = WIN_W'(1);
      shadow_cfg.window_width  = WIN_W'(1);
      shadow_cfg.step_rows     = STEP_W'(1);
      shadow_cfg.step_cols     = STEP_W'(1);
      krow         = 0;
      kcol         = 0;
      out_row      = 0;
      out_col      = 0;
      rows_latched = 0;
      cols_latched = 0;
      pass_open    = 1'b0;
      column_q.delete();
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[ADDR_W-1:2]))
          REG_IMAGE_HEIGHT:  shadow_cfg.image_height  = pwdata[IMG_W-1:0];
          REG_IMAGE_WIDTH:   shadow_cfg.image_width   = pwdata[IMG_W-1:0];
          REG_WINDOW_HEIGHT: shadow_cfg.window_height = pwdata[WIN_W-1:0];
          REG_WINDOW_WIDTH:  shadow_cfg.window_width  = pwdata[WIN_W-1:0];
          REG_PAD_ROWS:      shadow_cfg.pad_rows      = pwdata[PAD_W-1:0];
          REG_PAD_COLS:      shadow_cfg.pad_cols      = pwdata[PAD_W-1:0];
          REG_STEP_ROWS:     shadow_cfg.step_rows     = pwdata[STEP_W-1:0];
          REG_STEP_COLS:     shadow_cfg.step_cols     = pwdata[STEP_W-1:0];
          default:           shadow_cfg = shadow_cfg;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (column_q.size() == 0) begin
          $error("result transaction with no expected entry: offset %0d", source_offset_i);
          error_count_o++;
        end else begin
          want = column_q.pop_front();
          compare_field("source_offset", want.offset, source_offset_i);
          compare_field("is_padding", want.padding, is_padding_i);
          compare_field("last", want.last, last_i);
          compare_field("geometry_error", want.geo_err, geometry_error_i);
        end
      end

      if (in_valid_i && in_ready_i) begin
        column_q.push_back(next_entry(restart_i));
      end
      pending_o = column_q.size();
    end
  end

endmodule

### sim/tb_im2col_address_generator.sv
`timescale 1ns / 1ps
module tb_im2col_address_generator;
  import im2col_pkg::*;

  localparam int DIL_H         = 1;
  localparam int DIL_W         = 1;
  localparam int DIM_BITS      = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 25;
  localparam int DRAIN_LIMIT   = 20000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              restart = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [OFFS_W-1:0] source_offset;
  logic              is_padding;
  logic              last_entry;
  logic              geometry_error;
  int                error_count;
  int                pending;
  bit                steady = 1'b0;
  bit                hold_request = 1'b0;

  always #2 clk = ~clk;

  im2col_address_generator #(
    .ROW_DIL (DIL_H),
    .COL_DIL (DIL_W),
    .DIM_BITS(DIM_BITS)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .restart_i       (restart),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .source_offset_o (source_offset),
    .is_padding_o    (is_padding),
    .last_o          (last_entry),
    .geometry_error_o(geometry_error)
  );

  im2col_order_checker #(
    .DIL_H   (DIL_H),
    .DIL_W   (DIL_W),
    .DIM_BITS(DIM_BITS)
  ) checker_inst (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .restart_i       (restart),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .source_offset_i (source_offset),
    .is_padding_i    (is_padding),
    .last_i          (last_entry),
    .geometry_error_i(geometry_error),
    .error_count_o   (error_count),
    .pending_o       (pending)
  );

  task automatic write_reg(input reg_idx_e idx, input int unsigned value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_item(input logic fresh);
    @(negedge clk);
    if (!steady && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    restart  <= fresh;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid, waits for every expected entry, then lets the pipeline go quiet.
  task automatic settle();
    int waited;
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pick_geometry(input bit wide);
    write_reg(REG_IMAGE_HEIGHT, wide ? $urandom_range(4095) : $urandom_range(9));
    write_reg(REG_IMAGE_WIDTH, wide ? $urandom_range(4095) : $urandom_range(9));
    write_reg(REG_WINDOW_HEIGHT, wide ? $urandom_range(31) : $urandom_range(5));
    write_reg(REG_WINDOW_WIDTH, wide ? $urandom_range(31) : $urandom_range(5));
    write_reg(REG_PAD_ROWS, wide ? $urandom_range(15) : $urandom_range(3));
    write_reg(REG_PAD_COLS, wide ? $urandom_range(15) : $urandom_range(3));
    write_reg(REG_STEP_ROWS, wide ? $urandom_range(31) : $urandom_range(4));
    write_reg(REG_STEP_COLS, wide ? $urandom_range(31) : $urandom_range(4));
  endtask

  // Result side: random back-pressure, none in the steady phase, and one long hold-off.
  initial begin
    int held;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) begin
          @(negedge clk);
        end
        hold_request = 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 15);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    bit wide;
    int count;
    int restart_pct;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Reset geometry is a single-entry pass, so every request closes a pass.
    send_item(1'b0);
    send_item(1'b1);
    settle();

    // A window larger than the unpadded image gives no output positions.
    write_reg(REG_IMAGE_HEIGHT, 3);
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_WINDOW_HEIGHT, 5);
    write_reg(REG_WINDOW_WIDTH, 5);
    send_item(1'b0);
    send_item(1'b0);
    settle();

    // Empty image with padding: every position is padding. Zero window and stride act as 1.
    write_reg(REG_IMAGE_HEIGHT, 0);
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_WINDOW_HEIGHT, 0);
    write_reg(REG_WINDOW_WIDTH, 0);
    write_reg(REG_PAD_ROWS, 1);
    write_reg(REG_PAD_COLS, 1);
    write_reg(REG_STEP_ROWS, 0);
    write_reg(REG_STEP_COLS, 0);
    repeat (5) send_item(1'b0);
    settle();

    // Largest image, window above its maximum, widest padding and stride.
    write_reg(REG_IMAGE_HEIGHT, 4095);
    write_reg(REG_IMAGE_WIDTH, 4095);
    write_reg(REG_WINDOW_HEIGHT, 31);
    write_reg(REG_WINDOW_WIDTH, 31);
    write_reg(REG_PAD_ROWS, 15);
    write_reg(REG_PAD_COLS, 15);
    write_reg(REG_STEP_ROWS, 31);
    write_reg(REG_STEP_COLS, 31);
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    settle();

    // Output size saturates; then the width changes while the pass is still open.
    write_reg(REG_WINDOW_HEIGHT, 1);
    write_reg(REG_WINDOW_WIDTH, 1);
    write_reg(REG_STEP_ROWS, 1);
    write_reg(REG_STEP_COLS, 1);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    settle();
    write_reg(REG_IMAGE_WIDTH, 5);
    send_item(1'b0);
    send_item(1'b0);
    settle();

    // Narrowing the window mid-pass leaves the kernel column counter past its limit.
    write_reg(REG_IMAGE_HEIGHT, 1);
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_WINDOW_HEIGHT, 2);
    write_reg(REG_WINDOW_WIDTH, 3);
    write_reg(REG_PAD_ROWS, 1);
    write_reg(REG_PAD_COLS, 1);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    settle();
    write_reg(REG_WINDOW_WIDTH, 1);
    repeat (4) send_item(1'b0);
    settle();

    for (int ph = 0; ph < 28; ph++) begin
      wide = ($urandom_range(7) == 0);
      pick_geometry(wide);
      steady = (ph == 4);
      if (ph == 9) begin
        hold_request = 1'b1;
      end
      // Most phases run whole passes; a few restart often.
      restart_pct = (ph % 7 == 6) ? 30 : 3;
      count = wide ? 10 : 55;
      repeat (count) send_item($urandom_range(99) < restart_pct);
      settle();
    end
    steady = 1'b0;

    if (error_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
